FILE: src/lzswd_pkg.sv
package lzswd_pkg;

  localparam int WINDOW_BITS = 13;
  localparam int LENGTH_BITS = 4;
  localparam int WINDOW_SIZE = 1 << WINDOW_BITS;
  localparam int TOKEN_LEN   = 1 + WINDOW_BITS + LENGTH_BITS;
  localparam int CNT_W       = $clog2(TOKEN_LEN + 1);
  localparam int LIT_COUNT   = 9;
  localparam int END_COUNT   = 1 + WINDOW_BITS;
  localparam int MIN_MATCH   = 3;
  localparam int LEN_W       = LENGTH_BITS + 1;
  localparam int MAX_RESULTS = 19;
  localparam int NRES_W      = $clog2(MAX_RESULTS + 1);
  localparam int COUNT_W     = 24;
  localparam int PAD_BITS    = 64;
  localparam int PAD_W       = $clog2(PAD_BITS);

  localparam logic [1:0] STATUS_DATA     = 2'd0;
  localparam logic [1:0] STATUS_DONE     = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_BITS,
    ST_COPY,
    ST_FINAL
  } state_t;

  typedef enum logic [1:0] {
    TK_NONE,
    TK_LIT,
    TK_END,
    TK_MATCH
  } tok_kind_t;

  typedef struct packed {
    logic clear_step;
    logic load_in;
    logic feed;
    logic emit_lit;
    logic emit_end;
    logic start_copy;
    logic emit_copy;
    logic flush;
  } ctrl_cmd_t;

  typedef struct packed {
    tok_kind_t tok_kind;
    logic      can_push;
    logic      out_free;
    logic      hold_valid;
    logic      emit_term;
    logic      copy_last;
    logic      bits_done;
    logic      clear_last;
  } dp_status_t;

endpackage

FILE: src/lzswd_in_if.sv
interface lzswd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] packed_byte;
  logic       stream_end;

  modport source (output valid, output packed_byte, output stream_end, input ready);
  modport sink (input valid, input packed_byte, input stream_end, output ready);
endinterface

FILE: src/lzswd_out_if.sv
interface lzswd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] plain_byte;
  logic [1:0] status;
  logic       last_of_run;

  modport source (output valid, output plain_byte, output status, output last_of_run,
                  input ready);
  modport sink (input valid, input plain_byte, input status, input last_of_run,
                output ready);
endinterface

FILE: src/lzswd_ctrl.sv
module lzswd_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  lzswd_pkg::dp_status_t sts,
  output lzswd_pkg::ctrl_cmd_t  cmd
);

  lzswd_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lzswd_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lzswd_pkg::ST_CLEAR: begin
        if (sts.clear_last) state_nxt = lzswd_pkg::ST_IDLE;
      end
      lzswd_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = lzswd_pkg::ST_BITS;
      end
      lzswd_pkg::ST_BITS: begin
        if (sts.bits_done) begin
          state_nxt = lzswd_pkg::ST_FINAL;
        end else begin
          case (sts.tok_kind)
            lzswd_pkg::TK_LIT: begin
              if (sts.can_push && sts.emit_term) state_nxt = lzswd_pkg::ST_FINAL;
            end
            lzswd_pkg::TK_END: begin
              if (sts.can_push) state_nxt = lzswd_pkg::ST_FINAL;
            end
            lzswd_pkg::TK_MATCH: state_nxt = lzswd_pkg::ST_COPY;
            default: state_nxt = lzswd_pkg::ST_BITS;
          endcase
        end
      end
      lzswd_pkg::ST_COPY: begin
        if (sts.can_push) begin
          if (sts.emit_term) state_nxt = lzswd_pkg::ST_FINAL;
          else if (sts.copy_last) state_nxt = lzswd_pkg::ST_BITS;
        end
      end
      lzswd_pkg::ST_FINAL: begin
        if (!sts.hold_valid || sts.out_free) state_nxt = lzswd_pkg::ST_IDLE;
      end
      default: state_nxt = lzswd_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      lzswd_pkg::ST_CLEAR: cmd.clear_step = 1'b1;
      lzswd_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      lzswd_pkg::ST_BITS: begin
        if (!sts.bits_done) begin
          case (sts.tok_kind)
            lzswd_pkg::TK_LIT: begin
              cmd.feed     = sts.can_push;
              cmd.emit_lit = sts.can_push;
            end
            lzswd_pkg::TK_END: begin
              cmd.feed     = sts.can_push;
              cmd.emit_end = sts.can_push;
            end
            lzswd_pkg::TK_MATCH: begin
              cmd.feed       = 1'b1;
              cmd.start_copy = 1'b1;
            end
            default: cmd.feed = 1'b1;
          endcase
        end
      end
      lzswd_pkg::ST_COPY: cmd.emit_copy = sts.can_push;
      lzswd_pkg::ST_FINAL: cmd.flush = sts.hold_valid && sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

FILE: src/lzswd_datapath.sv
module lzswd_datapath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  lzswd_pkg::ctrl_cmd_t           cmd,
  output lzswd_pkg::dp_status_t          sts,
  input  logic [7:0]                     in_byte,
  input  logic                           in_end,
  input  logic                           cfg_wr_en,
  input  logic [lzswd_pkg::COUNT_W-1:0]  cfg_wr_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [7:0]                     out_byte,
  output logic [1:0]                     out_status,
  output logic                           out_last
);

  localparam int WB = lzswd_pkg::WINDOW_BITS;
  localparam int LB = lzswd_pkg::LENGTH_BITS;
  localparam int TL = lzswd_pkg::TOKEN_LEN;

  logic [7:0] window_mem [lzswd_pkg::WINDOW_SIZE];

  // control state
  logic [lzswd_pkg::COUNT_W-1:0] limit_r, limit_nxt;
  logic [lzswd_pkg::COUNT_W-1:0] prod_r, prod_nxt;
  logic [WB-1:0]                 wp_r, wp_nxt;
  logic [WB-1:0]                 clr_addr_r, clr_addr_nxt;
  logic [TL-1:0]                 tok_r, tok_nxt;
  logic [lzswd_pkg::CNT_W-1:0]   tcount_r, tcount_nxt;
  logic [lzswd_pkg::NRES_W-1:0]  nres_r, nres_nxt;
  logic [2:0]                    bit_idx_r, bit_idx_nxt;
  logic                          pad_r, pad_nxt;
  logic [lzswd_pkg::PAD_W-1:0]   pad_cnt_r, pad_cnt_nxt;
  logic                          bits_done_r, bits_done_nxt;
  logic [WB-1:0]                 pos_r, pos_nxt;
  logic [lzswd_pkg::LEN_W-1:0]   len_r, len_nxt;
  logic                          hold_valid_r, hold_valid_nxt;
  logic                          out_valid_r, out_valid_nxt;

  // payload
  logic [7:0] byte_r;
  logic       end_r;
  logic [7:0] hold_byte_r;
  logic [1:0] hold_status_r;
  logic [7:0] out_byte_r;
  logic [1:0] out_status_r;
  logic       out_last_r;
  logic [7:0] rd_data_r;

  logic                        cur_bit;
  logic [TL-1:0]               new_tok;
  logic [lzswd_pkg::CNT_W-1:0] new_cnt;
  logic                        flag;
  lzswd_pkg::tok_kind_t        tok_kind;
  logic                        emit_term;
  logic                        out_free;
  logic                        can_push;
  logic                        push;
  logic [7:0]                  push_byte;
  logic [1:0]                  push_status;
  logic                        data_wr;
  logic                        restart;
  logic                        mem_we;
  logic [WB-1:0]               mem_waddr;
  logic [7:0]                  mem_wdata;
  logic                        mem_re;
  logic [WB-1:0]               mem_raddr;

  assign cur_bit = pad_r ? 1'b0 : byte_r[bit_idx_r];
  assign new_tok = {tok_r[TL-2:0], cur_bit};
  assign new_cnt = tcount_r + 1'b1;
  assign flag    = new_tok[tcount_r];

  always_comb begin
    tok_kind = lzswd_pkg::TK_NONE;
    if (flag) begin
      if (new_cnt == lzswd_pkg::CNT_W'(lzswd_pkg::LIT_COUNT)) tok_kind = lzswd_pkg::TK_LIT;
    end else if (new_cnt == lzswd_pkg::CNT_W'(lzswd_pkg::END_COUNT) &&
                 new_tok[WB-1:0] == '0) begin
      tok_kind = lzswd_pkg::TK_END;
    end else if (new_cnt == lzswd_pkg::CNT_W'(TL)) begin
      tok_kind = lzswd_pkg::TK_MATCH;
    end
  end

  assign emit_term = (prod_r >= limit_r) ||
                     (nres_r >= lzswd_pkg::NRES_W'(lzswd_pkg::MAX_RESULTS - 1));
  assign out_free  = !out_valid_r || out_ready;
  assign can_push  = !hold_valid_r || out_free;
  assign push      = cmd.emit_lit || cmd.emit_end || cmd.emit_copy;
  assign data_wr   = (cmd.emit_lit || cmd.emit_copy) && !emit_term;
  assign restart   = cmd.emit_end || ((cmd.emit_lit || cmd.emit_copy) && emit_term);

  always_comb begin
    push_byte   = 8'd0;
    push_status = lzswd_pkg::STATUS_DATA;
    if (cmd.emit_end) begin
      push_status = lzswd_pkg::STATUS_DONE;
    end else if (prod_r >= limit_r) begin
      push_status = lzswd_pkg::STATUS_OVERFLOW;
    end else if (nres_r >= lzswd_pkg::NRES_W'(lzswd_pkg::MAX_RESULTS - 1)) begin
      push_status = lzswd_pkg::STATUS_DONE;
    end else begin
      push_byte = cmd.emit_copy ? rd_data_r : new_tok[7:0];
    end
  end

  assign mem_we    = cmd.clear_step || data_wr;
  assign mem_waddr = cmd.clear_step ? clr_addr_r : wp_r;
  assign mem_wdata = cmd.clear_step ? 8'd0 : push_byte;
  assign mem_re    = cmd.start_copy || cmd.emit_copy;
  assign mem_raddr = cmd.start_copy ? new_tok[LB +: WB] : pos_r + 1'b1;

  always_comb begin
    limit_nxt      = cfg_wr_en ? cfg_wr_data : limit_r;
    prod_nxt       = prod_r;
    wp_nxt         = wp_r;
    clr_addr_nxt   = cmd.clear_step ? clr_addr_r + 1'b1 : clr_addr_r;
    tok_nxt        = tok_r;
    tcount_nxt     = tcount_r;
    nres_nxt       = nres_r;
    bit_idx_nxt    = bit_idx_r;
    pad_nxt        = pad_r;
    pad_cnt_nxt    = pad_cnt_r;
    bits_done_nxt  = bits_done_r;
    pos_nxt        = pos_r;
    len_nxt        = len_r;
    hold_valid_nxt = hold_valid_r;
    out_valid_nxt  = out_valid_r && !out_ready;

    if (cmd.load_in) begin
      bit_idx_nxt   = 3'd7;
      pad_nxt       = 1'b0;
      pad_cnt_nxt   = '0;
      bits_done_nxt = 1'b0;
      nres_nxt      = '0;
    end

    if (cmd.feed) begin
      if (tok_kind == lzswd_pkg::TK_NONE) begin
        tok_nxt    = new_tok;
        tcount_nxt = new_cnt;
      end else begin
        tok_nxt    = '0;
        tcount_nxt = '0;
      end
      if (!pad_r) begin
        if (bit_idx_r == 3'd0) begin
          if (end_r) pad_nxt = 1'b1;
          else bits_done_nxt = 1'b1;
        end else begin
          bit_idx_nxt = bit_idx_r - 1'b1;
        end
      end else if (pad_cnt_r == lzswd_pkg::PAD_W'(lzswd_pkg::PAD_BITS - 1)) begin
        bits_done_nxt = 1'b1;
      end else begin
        pad_cnt_nxt = pad_cnt_r + 1'b1;
      end
    end

    if (cmd.start_copy) begin
      pos_nxt = new_tok[LB +: WB];
      len_nxt = lzswd_pkg::LEN_W'(new_tok[LB-1:0]) + lzswd_pkg::LEN_W'(lzswd_pkg::MIN_MATCH);
    end
    if (cmd.emit_copy) begin
      pos_nxt = pos_r + 1'b1;
      len_nxt = len_r - 1'b1;
    end

    if (push) begin
      nres_nxt       = nres_r + 1'b1;
      hold_valid_nxt = 1'b1;
      if (hold_valid_r) out_valid_nxt = 1'b1;
    end else if (cmd.flush) begin
      hold_valid_nxt = 1'b0;
      out_valid_nxt  = 1'b1;
    end

    if (data_wr) begin
      wp_nxt   = wp_r + 1'b1;
      prod_nxt = prod_r + 1'b1;
    end

    if (restart) begin
      wp_nxt     = WB'(1);
      prod_nxt   = '0;
      tok_nxt    = '0;
      tcount_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r      <= '1;
      prod_r       <= '0;
      wp_r         <= WB'(1);
      clr_addr_r   <= '0;
      tok_r        <= '0;
      tcount_r     <= '0;
      nres_r       <= '0;
      bit_idx_r    <= '0;
      pad_r        <= 1'b0;
      pad_cnt_r    <= '0;
      bits_done_r  <= 1'b0;
      pos_r        <= '0;
      len_r        <= '0;
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      limit_r      <= limit_nxt;
      prod_r       <= prod_nxt;
      wp_r         <= wp_nxt;
      clr_addr_r   <= clr_addr_nxt;
      tok_r        <= tok_nxt;
      tcount_r     <= tcount_nxt;
      nres_r       <= nres_nxt;
      bit_idx_r    <= bit_idx_nxt;
      pad_r        <= pad_nxt;
      pad_cnt_r    <= pad_cnt_nxt;
      bits_done_r  <= bits_done_nxt;
      pos_r        <= pos_nxt;
      len_r        <= len_nxt;
      hold_valid_r <= hold_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      byte_r <= in_byte;
      end_r  <= in_end;
    end
    if (push) begin
      hold_byte_r   <= push_byte;
      hold_status_r <= push_status;
    end
    if (push && hold_valid_r) begin
      out_byte_r   <= hold_byte_r;
      out_status_r <= hold_status_r;
      out_last_r   <= 1'b0;
    end else if (cmd.flush) begin
      out_byte_r   <= hold_byte_r;
      out_status_r <= hold_status_r;
      out_last_r   <= 1'b1;
    end
  end

  // window RAM, write-through on a same-address read
  always_ff @(posedge clk) begin
    if (mem_we) window_mem[mem_waddr] <= mem_wdata;
    if (mem_re) begin
      if (mem_we && mem_waddr == mem_raddr) rd_data_r <= mem_wdata;
      else rd_data_r <= window_mem[mem_raddr];
    end
  end

  always_comb begin
    sts            = '0;
    sts.tok_kind   = tok_kind;
    sts.can_push   = can_push;
    sts.out_free   = out_free;
    sts.hold_valid = hold_valid_r;
    sts.emit_term  = emit_term;
    sts.copy_last  = (len_r == lzswd_pkg::LEN_W'(1));
    sts.bits_done  = bits_done_r;
    sts.clear_last = (clr_addr_r == '1);
  end

  assign out_valid  = out_valid_r;
  assign out_byte   = out_byte_r;
  assign out_status = out_status_r;
  assign out_last   = out_last_r;

endmodule

FILE: src/lzss_window_decompressor.sv
// Per input byte: a transfer, then its bits one at a time (8, or up to 72 with the zero fill
// of a final byte), a step once the bits run out, a step for each byte copied from the window
// RAM and a last step to hand over the closing result.
// One input byte is worked on at a time; output stalls hold the bit parser.
// Reset is synchronous, active low; after it a clearing pass over all 8192 entries zeroes
// the window RAM, during which in_ch.ready stays low and cfg writes are still taken.
module lzss_window_decompressor (
  input  logic                          clk,
  input  logic                          rst_n,
  lzswd_in_if.sink                      in_ch,
  lzswd_out_if.source                   out_ch,
  input  logic                          cfg_wr_en,
  input  logic [lzswd_pkg::COUNT_W-1:0] cfg_wr_data
);

  lzswd_pkg::ctrl_cmd_t  cmd;
  lzswd_pkg::dp_status_t sts;

  lzswd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lzswd_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_byte     (in_ch.packed_byte),
    .in_end      (in_ch.stream_end),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_byte    (out_ch.plain_byte),
    .out_status  (out_ch.status),
    .out_last    (out_ch.last_of_run)
  );

endmodule

FILE: sim/tb_top.sv
module tb_top;

  localparam int STALL_LIMIT   = 40000;
  localparam int SETTLE_CYCLES = 150;
  localparam int HOLD_CYCLES   = 400;
  localparam int TOK_W         = lzswd_pkg::TOKEN_LEN;

  typedef struct packed {
    logic [7:0] plain_byte;
    logic [1:0] status;
    logic       last_of_run;
  } plain_res_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_wr_en;
  logic [lzswd_pkg::COUNT_W-1:0] cfg_wr_data;

  lzswd_in_if  in_ch ();
  lzswd_out_if out_ch ();

  lzss_window_decompressor dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // decoder shadow state
  logic [7:0]                    win_mem [lzswd_pkg::WINDOW_SIZE];
  logic [12:0]                   wr_ptr;
  logic [lzswd_pkg::COUNT_W-1:0] n_produced;
  logic [lzswd_pkg::COUNT_W-1:0] out_limit;
  logic [TOK_W-1:0]              tok_bits;
  int                            tok_cnt;
  int                            run_n;

  plain_res_t pending_plain [$];
  plain_res_t seen_r;
  bit         frame_bits [$];

  int  failures;
  int  n_items;
  int  n_results;
  int  n_done;
  int  n_overflow;
  int  stall_cycles = 0;
  bit  calm;
  bit  hold_req;
  int  hold_left;

  function automatic void restart_parser();
    wr_ptr     = 13'd1;
    n_produced = '0;
    tok_bits   = '0;
    tok_cnt    = 0;
  endfunction

  function automatic void put_result(input logic [7:0] v, input logic [1:0] st);
    plain_res_t r;
    r.plain_byte  = v;
    r.status      = st;
    r.last_of_run = 1'b0;
    pending_plain.push_back(r);
    run_n++;
  endfunction

  function automatic bit emit_byte(input logic [7:0] v);
    if (n_produced >= out_limit) begin
      put_result(8'h00, lzswd_pkg::STATUS_OVERFLOW);
      restart_parser();
      return 1'b1;
    end
    if (run_n >= lzswd_pkg::MAX_RESULTS - 1) begin
      put_result(8'h00, lzswd_pkg::STATUS_DONE);
      restart_parser();
      return 1'b1;
    end
    put_result(v, lzswd_pkg::STATUS_DATA);
    win_mem[wr_ptr] = v;
    wr_ptr++;
    n_produced++;
    return 1'b0;
  endfunction

  function automatic bit feed_bit(input logic b);
    logic [7:0]  lit;
    logic [12:0] pos;
    int          len;
    tok_bits = {tok_bits[TOK_W-2:0], b};
    tok_cnt++;
    if (tok_bits[tok_cnt-1]) begin
      if (tok_cnt == lzswd_pkg::LIT_COUNT) begin
        lit      = tok_bits[7:0];
        tok_bits = '0;
        tok_cnt  = 0;
        return emit_byte(lit);
      end
      return 1'b0;
    end
    if (tok_cnt == lzswd_pkg::END_COUNT && tok_bits[lzswd_pkg::WINDOW_BITS-1:0] == '0) begin
      put_result(8'h00, lzswd_pkg::STATUS_DONE);
      restart_parser();
      return 1'b1;
    end
    if (tok_cnt == TOK_W) begin
      pos      = tok_bits[TOK_W-2:lzswd_pkg::LENGTH_BITS];
      len      = int'(tok_bits[lzswd_pkg::LENGTH_BITS-1:0]) + lzswd_pkg::MIN_MATCH;
      tok_bits = '0;
      tok_cnt  = 0;
      for (int i = 0; i < len; i++) begin
        lit = win_mem[pos];
        pos++;
        if (emit_byte(lit)) return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic void decode_byte(input logic [7:0] b, input logic fin);
    bit         ended = 1'b0;
    plain_res_t r;
    run_n = 0;
    for (int i = 7; i >= 0 && !ended; i--) ended = feed_bit(b[i]);
    if (fin) begin
      for (int i = 0; i < lzswd_pkg::PAD_BITS && !ended; i++) ended = feed_bit(1'b0);
    end
    if (run_n > 0) begin
      r = pending_plain.pop_back();
      r.last_of_run = 1'b1;
      pending_plain.push_back(r);
    end
  endfunction

  // stimulus helpers
  task automatic send_byte(input logic [7:0] b, input logic fin);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 11) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.packed_byte <= b;
    in_ch.stream_end  <= fin;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    decode_byte(b, fin);
    n_items++;
  endtask

  function automatic void push_bits(input logic [TOK_W-1:0] v, input int w);
    for (int i = w - 1; i >= 0; i--) frame_bits.push_back(v[i]);
  endfunction

  // with_end: explicit end token, junk after it; otherwise zero fill and stream_end
  task automatic send_stream(input bit with_end);
    logic [7:0] b;
    if (with_end) push_bits('0, lzswd_pkg::END_COUNT);
    while (frame_bits.size() % 8 != 0)
      frame_bits.push_back(with_end ? 1'($urandom_range(1)) : 1'b0);
    while (frame_bits.size() > 0) begin
      for (int i = 7; i >= 0; i--) b[i] = frame_bits.pop_front();
      send_byte(b, frame_bits.size() == 0 && (!with_end || $urandom_range(1) == 1));
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    wait (pending_plain.size() == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_limit(input logic [lzswd_pkg::COUNT_W-1:0] v);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    out_limit = v;
  endtask

  // tests
  task automatic test_literals_and_end();
    push_bits(TOK_W'({1'b1, 8'h00}), 9);
    push_bits(TOK_W'({1'b1, 8'hFF}), 9);
    push_bits(TOK_W'({1'b1, 8'h5A}), 9);
    send_stream(1'b1);
  endtask

  task automatic test_window_copies();
    push_bits({1'b0, 13'd1, 4'hF}, TOK_W);
    push_bits({1'b0, 13'h1FFF, 4'h0}, TOK_W);
    send_stream(1'b0);
  endtask

  // partial copy token finished by the zero fill, then overflow part way through
  task automatic test_output_limit();
    write_limit(24'd5);
    push_bits(TOK_W'({1'b0, 13'd2, 2'b11}), 16);
    send_stream(1'b0);
    drain_results();
  endtask

  task automatic test_zero_limit();
    write_limit('0);
    push_bits(TOK_W'(8'hFF), 8);
    send_stream(1'b0);
    drain_results();
  endtask

  // 18-byte copy ends on the first bit of the final byte; zero fill then completes a literal
  task automatic test_result_slots_full();
    write_limit(24'hFF_FFFF);
    for (int i = 0; i < 7; i++) push_bits(TOK_W'({1'b1, 8'(i * 37 + 1)}), 9);
    push_bits({1'b0, 13'd1, 4'hF}, TOK_W);
    push_bits(TOK_W'({1'b1, 6'($urandom)}), 7);
    send_stream(1'b0);
  endtask

  task automatic test_random_streams(input int count);
    int stop_at;
    int ntok;
    stop_at = n_items + count;
    while (n_items < stop_at) begin
      if ($urandom_range(99) < 80) begin
        ntok = $urandom_range(8, 1);
        repeat (ntok) begin
          if ($urandom_range(99) < 60)
            push_bits(TOK_W'({1'b1, 8'($urandom)}), 9);
          else
            push_bits({1'b0, 13'($urandom_range(99) < 50 ? $urandom_range(64, 1)
                                                           : $urandom_range(8191, 1)),
                       4'($urandom)}, TOK_W);
        end
        send_stream(1'($urandom_range(1)));
      end else begin
        ntok = $urandom_range(4, 1);
        for (int k = 1; k <= ntok; k++)
          send_byte(8'($urandom), k == ntok || $urandom_range(7) == 0);
      end
    end
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    test_random_streams(20);
    drain_results();
  endtask

  // result checking
  always @(posedge clk) begin
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      n_results++;
      if (out_ch.status == lzswd_pkg::STATUS_DONE) n_done++;
      if (out_ch.status == lzswd_pkg::STATUS_OVERFLOW) n_overflow++;
      if (pending_plain.size() == 0) begin
        $error("unexpected result: plain_byte %0h status %0d", out_ch.plain_byte,
               out_ch.status);
        failures++;
      end else begin
        seen_r = pending_plain.pop_front();
        if (out_ch.plain_byte !== seen_r.plain_byte) begin
          $error("plain_byte: expected %0h, actual %0h", seen_r.plain_byte,
                 out_ch.plain_byte);
          failures++;
        end
        if (out_ch.status !== seen_r.status) begin
          $error("status: expected %0d, actual %0d", seen_r.status, out_ch.status);
          failures++;
        end
        if (out_ch.last_of_run !== seen_r.last_of_run) begin
          $error("last_of_run: expected %0b, actual %0b", seen_r.last_of_run,
                 out_ch.last_of_run);
          failures++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver
  initial begin
    hold_left    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= calm || $urandom_range(99) >= 11;
      end
    end
  end

  initial begin
    rst_n             = 1'b0;
    cfg_wr_en         = 1'b0;
    cfg_wr_data       = '0;
    in_ch.valid       = 1'b0;
    in_ch.packed_byte = '0;
    in_ch.stream_end  = 1'b0;
    failures          = 0;
    n_items           = 0;
    n_results         = 0;
    n_done            = 0;
    n_overflow        = 0;
    calm              = 1'b0;
    hold_req          = 1'b0;
    for (int i = 0; i < lzswd_pkg::WINDOW_SIZE; i++) win_mem[i] = 8'h00;
    out_limit = 24'hFF_FFFF;
    restart_parser();

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    write_limit(24'hFF_FFFF);

    test_literals_and_end();
    test_window_copies();
    drain_results();
    test_output_limit();
    test_zero_limit();
    test_result_slots_full();
    drain_results();

    calm = 1'b1;
    test_random_streams(25);
    calm = 1'b0;
    test_random_streams(12);
    test_backpressure();
    write_limit(24'($urandom_range(40, 8)));
    test_random_streams(20);
    drain_results();
    write_limit(24'd1);
    test_random_streams(8);
    drain_results();
    write_limit(24'hFF_FFFF);
    test_random_streams(20);

    @(negedge clk);
    in_ch.valid <= 1'b0;
    wait (pending_plain.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("%0d compressed bytes in, %0d results checked (%0d end, %0d overflow)",
             n_items, n_results, n_done, n_overflow);
    $display("limits 0, 1, 5, small random and full; long output stall and full drains");
    if (failures == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
